// File: hdl/pss_pkg.sv
`timescale 1ns / 1ps
package pss_pkg;
    localparam logic [2:0] KIND_CREATE   = 3'd0;
    localparam logic [2:0] KIND_TICK     = 3'd1;
    localparam logic [2:0] KIND_SLEEP    = 3'd2;
    localparam logic [2:0] KIND_QUERY    = 3'd3;
    localparam logic [2:0] KIND_DISPATCH = 3'd4;

    localparam logic [1:0] ST_FREE  = 2'd0;
    localparam logic [1:0] ST_READY = 2'd1;
    localparam logic [1:0] ST_SLEEP = 2'd2;
    localparam logic [1:0] ST_RUN   = 2'd3;

    localparam logic [1:0] STAT_DONE    = 2'd0;
    localparam logic [1:0] STAT_NO_FREE = 2'd1;
    localparam logic [1:0] STAT_IGNORED = 2'd2;

    localparam logic [7:0] LIMIT_RESET = 8'd10;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_INIT  = 6'b000010,
        S_RD    = 6'b000100,
        S_EXEC  = 6'b001000,
        S_SCAN  = 6'b010000,
        S_OUT   = 6'b100000
    } t_state;
endpackage

// File: hdl/process_slot_scheduler.sv
`timescale 1ns / 1ps
// Create, sleep, query and dispatch pass through S_RD, S_OUT and S_EXEC before the result;
// a tick first runs the one-slot-per-cycle wake scan of the slot memory in S_SCAN and then
// those states. One item is in work at a time; the next is taken once the result leaves.
// Reset: after i_rst_n is released an init pass over every slot clears the slot
// memory and loads the free id queue; no item is taken during it.
module process_slot_scheduler #(
    parameter int SLOT_COUNT = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [7:0]  i_cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [2:0] kind, [34:3] entry_address, [50:35] sleep_ticks, [55:51] zero
    input  logic [55:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [1:0] status, [5:2] process_id, [10:6] running_id, [11] preempted,
    // [16:12] woken_count, [48:17] start_address, [55:49] zero
    output logic [55:0] m_axis_tdata
);
    import pss_pkg::*;

    localparam int IW = $clog2(SLOT_COUNT);
    localparam int CW = $clog2(SLOT_COUNT + 1);
    localparam int SW = 2 + 32 + 8 + 32;

    // slot memory: {state, wake, runtime, entry}
    logic [SW-1:0] r_slot_mem [SLOT_COUNT];
    logic [IW-1:0] r_free_mem [SLOT_COUNT];
    logic [IW-1:0] r_rdy_mem  [SLOT_COUNT];

    t_state        r_state;
    logic [7:0]    r_limit;
    logic [31:0]   r_now;
    logic          r_run_vld;
    logic [IW-1:0] r_run_id;
    logic [IW-1:0] r_free_head, r_rdy_head;
    logic [CW-1:0] r_free_cnt, r_rdy_cnt;
    logic [2:0]    r_kind;
    logic [31:0]   r_entry;
    logic [15:0]   r_nap;
    logic [IW-1:0] r_addr, r_scan;
    logic          r_scan_done;
    logic          r_scan_vld;
    logic [SW-1:0] r_rdata;
    logic [IW-1:0] r_free_q, r_rdy_q;
    logic [1:0]    r_stat;
    logic [IW-1:0] r_pid;
    logic          r_pre;
    logic [4:0]    r_woken;
    logic [31:0]   r_start;
    logic          r_ovld;

    logic          we;
    logic [IW-1:0] wa;
    logic [SW-1:0] wd;
    logic          rdy_we;
    logic [IW-1:0] rdy_wa, rdy_wd;
    logic [IW-1:0] rd_addr;

    logic [1:0]  rd_st;
    logic [31:0] rd_wake, rd_ent;
    logic [7:0]  rd_rt, rt_inc;
    assign rd_st   = r_rdata[SW-1 -: 2];
    assign rd_wake = r_rdata[SW-3 -: 32];
    assign rd_rt   = r_rdata[39:32];
    assign rd_ent  = r_rdata[31:0];
    assign rt_inc  = rd_rt + 8'd1;

    function automatic logic [IW-1:0] wrap_add(input logic [IW-1:0] h, input logic [CW-1:0] c);
        logic [CW:0] s;
        s = (CW+1)'(h) + (CW+1)'(c);
        if (s >= (CW+1)'(SLOT_COUNT)) s = s - (CW+1)'(SLOT_COUNT);
        return s[IW-1:0];
    endfunction

    function automatic logic [IW-1:0] inc_id(input logic [IW-1:0] h);
        return (h == IW'(SLOT_COUNT - 1)) ? '0 : h + IW'(1);
    endfunction

    assign o_cfg_ready   = 1'b1;
    assign s_axis_tready = (r_state == S_IDLE) && !r_ovld;
    assign m_axis_tvalid = r_ovld;
    assign m_axis_tdata  = {7'd0, r_start, r_woken, r_pre,
                            (r_run_vld ? 5'(r_run_id) : 5'h1f),
                            4'(r_pid), r_stat};

    // pick read address for the slot memory
    always_comb begin
        rd_addr = r_addr;
        if (r_state == S_SCAN) rd_addr = r_scan;
    end

    // memories: one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (we) r_slot_mem[wa] <= wd;
        r_rdata <= r_slot_mem[rd_addr];
        if (rdy_we) r_rdy_mem[rdy_wa] <= rdy_wd;
        r_rdy_q  <= r_rdy_mem[r_rdy_head];
        r_free_q <= r_free_mem[r_free_head];
        if (r_state == S_INIT) r_free_mem[r_scan] <= r_scan;
    end

    // write port control for init, create, tick, sleep, dispatch and the wake scan
    always_comb begin
        we = 1'b0; wa = r_addr; wd = r_rdata;
        rdy_we = 1'b0; rdy_wa = wrap_add(r_rdy_head, r_rdy_cnt); rdy_wd = r_addr;
        unique case (r_state)
            S_INIT: begin
                we = 1'b1; wa = r_scan; wd = '0;
            end
            S_EXEC: begin
                unique case (r_kind)
                    KIND_CREATE: if (r_free_cnt != '0) begin
                        we = 1'b1; wa = r_free_q;
                        wd = {ST_READY, 32'd0, 8'd0, r_entry};
                        rdy_we = (r_free_q != '0) && (r_rdy_cnt < CW'(SLOT_COUNT));
                        rdy_wd = r_free_q;
                    end
                    KIND_TICK: if (r_run_vld && r_run_id != '0) begin
                        we = 1'b1;
                        if (rt_inc >= r_limit) begin
                            wd = {ST_READY, rd_wake, rt_inc, rd_ent};
                            rdy_we = r_rdy_cnt < CW'(SLOT_COUNT);
                            rdy_wd = r_run_id;
                        end else begin
                            wd = {rd_st, rd_wake, rt_inc, rd_ent};
                        end
                    end
                    KIND_SLEEP: if (r_run_vld) begin
                        we = 1'b1;
                        wd = {ST_SLEEP, r_now + {16'd0, r_nap}, rd_rt, rd_ent};
                    end
                    KIND_DISPATCH: if (!r_run_vld) begin
                        we = 1'b1;
                        wd = {ST_RUN, rd_wake, 8'd0, rd_ent};
                    end
                    default: ;
                endcase
            end
            S_SCAN: if (r_scan_vld && rd_st == ST_SLEEP && rd_wake == r_now) begin
                we = 1'b1; wa = r_addr;
                wd = {ST_READY, rd_wake, rd_rt, rd_ent};
                rdy_we = r_rdy_cnt < CW'(SLOT_COUNT);
                rdy_wd = r_addr;
            end
            default: ;
        endcase
    end

    // control sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT; r_limit <= LIMIT_RESET; r_now <= '0;
            r_run_vld <= 1'b0; r_run_id <= '0;
            r_free_head <= '0; r_free_cnt <= CW'(SLOT_COUNT);
            r_rdy_head <= '0; r_rdy_cnt <= '0;
            r_scan <= '0; r_ovld <= 1'b0; r_addr <= '0; r_scan_done <= 1'b0;
            r_scan_vld <= 1'b0;
        end else begin
            if (i_cfg_valid) r_limit <= i_cfg_data;
            if (m_axis_tvalid && m_axis_tready) r_ovld <= 1'b0;
            if (rdy_we) r_rdy_cnt <= r_rdy_cnt + CW'(1);
            unique case (r_state)
                S_INIT: begin
                    r_scan <= inc_id(r_scan);
                    if (r_scan == IW'(SLOT_COUNT - 1)) r_state <= S_IDLE;
                end
                S_IDLE: if (s_axis_tvalid && s_axis_tready) begin
                    r_kind  <= s_axis_tdata[2:0];
                    r_entry <= s_axis_tdata[34:3];
                    r_nap   <= s_axis_tdata[50:35];
                    r_stat <= STAT_DONE; r_pid <= '0; r_pre <= 1'b0;
                    r_woken <= '0; r_start <= '0;
                    r_addr <= r_run_vld ? r_run_id : '0;
                    if (s_axis_tdata[2:0] == KIND_TICK) begin
                        r_now <= r_now + 32'd1;
                        r_scan <= '0; r_scan_done <= 1'b0; r_scan_vld <= 1'b0;
                        r_state <= S_SCAN;
                    end else begin
                        r_state <= S_RD;
                    end
                end
                S_SCAN: begin
                    // one slot per cycle; r_addr trails r_scan by the read latency
                    if (r_scan_vld && rd_st == ST_SLEEP && rd_wake == r_now)
                        r_woken <= r_woken + 5'd1;
                    r_scan_vld <= 1'b1;
                    if (r_scan == IW'(SLOT_COUNT - 1)) r_scan_done <= 1'b1;
                    if (r_scan_done) begin
                        r_addr <= r_run_vld ? r_run_id : '0;
                        r_state <= S_RD;
                    end else begin
                        r_addr <= r_scan;
                        r_scan <= inc_id(r_scan);
                    end
                end
                S_RD: begin
                    // take the dispatch target from the registered ready head
                    if (r_kind == KIND_DISPATCH && !r_run_vld)
                        r_addr <= (r_rdy_cnt != '0) ? r_rdy_q : '0;
                    r_state <= S_OUT;
                end
                S_OUT: r_state <= S_EXEC;
                S_EXEC: begin
                    r_state <= S_IDLE;
                    r_ovld <= 1'b1;
                    unique case (r_kind)
                        KIND_CREATE: begin
                            if (r_free_cnt == '0) r_stat <= STAT_NO_FREE;
                            else begin
                                r_pid <= r_free_q;
                                r_free_head <= inc_id(r_free_head);
                                r_free_cnt <= r_free_cnt - CW'(1);
                            end
                        end
                        KIND_TICK: begin
                            if (!r_run_vld) r_stat <= STAT_IGNORED;
                            else if (r_run_id != '0 && rt_inc >= r_limit) begin
                                r_run_vld <= 1'b0; r_pre <= 1'b1;
                            end
                        end
                        KIND_SLEEP: begin
                            if (!r_run_vld) r_stat <= STAT_IGNORED;
                            else r_run_vld <= 1'b0;
                        end
                        KIND_DISPATCH: begin
                            r_pid <= r_addr; r_start <= rd_ent;
                            if (!r_run_vld) begin
                                r_run_vld <= 1'b1; r_run_id <= r_addr;
                                if (r_rdy_cnt != '0) begin
                                    r_rdy_head <= inc_id(r_rdy_head);
                                    r_rdy_cnt <= r_rdy_cnt - CW'(1);
                                end
                            end
                        end
                        default: ;
                    endcase
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

// File: tb/tb_process_slot_scheduler.sv
`timescale 1ns / 1ps
module tb_process_slot_scheduler;
    import pss_pkg::*;

    localparam int SLOTS = 16;

    // one decoded result of the scheduler
    typedef struct packed {
        logic [1:0]  status;
        logic [3:0]  pid;
        logic [4:0]  running;
        logic        preempted;
        logic [4:0]  woken;
        logic [31:0] start;
    } sched_result_t;

    // Task table predictor plus the queue of results still due from the block.
    class sched_scoreboard;
        logic [7:0]    limit;
        logic [31:0]   now;
        logic [4:0]    runner;
        logic [1:0]    st [SLOTS];
        logic [31:0]   wake [SLOTS];
        logic [7:0]    runtime [SLOTS];
        logic [31:0]   entry [SLOTS];
        logic [3:0]    free_ids [$];
        logic [3:0]    ready_ids [$];
        sched_result_t due [$];
        int            errors;

        function void clear();
            limit = LIMIT_RESET;
            now = 0;
            runner = 5'h1f;
            free_ids.delete();
            ready_ids.delete();
            due.delete();
            errors = 0;
            for (int i = 0; i < SLOTS; i++) begin
                st[i] = ST_FREE;
                wake[i] = 0;
                runtime[i] = 0;
                entry[i] = 0;
                free_ids.push_back(i[3:0]);
            end
        endfunction

        function void push_ready(logic [3:0] id);
            if (ready_ids.size() < SLOTS) ready_ids.push_back(id);
        endfunction

        // Note an accepted request and queue the result it causes.
        function void note_request(logic [2:0] kind, logic [31:0] addr, logic [15:0] nap);
            sched_result_t r;
            logic [3:0] id;
            r = '0;
            case (kind)
                KIND_CREATE: begin
                    if (free_ids.size() == 0) begin
                        r.status = STAT_NO_FREE;
                    end else begin
                        id = free_ids.pop_front();
                        st[id] = ST_READY;
                        wake[id] = 0;
                        runtime[id] = 0;
                        entry[id] = addr;
                        if (id != 0) push_ready(id);
                        r.pid = id;
                    end
                end
                KIND_TICK: begin
                    now = now + 32'd1;
                    for (int k = 0; k < SLOTS; k++) begin
                        if (st[k] == ST_SLEEP && wake[k] == now) begin
                            push_ready(k[3:0]);
                            st[k] = ST_READY;
                            r.woken = r.woken + 5'd1;
                        end
                    end
                    if (runner[4]) begin
                        r.status = STAT_IGNORED;
                    end else if (runner != 0) begin
                        runtime[runner] = runtime[runner] + 8'd1;
                        if (runtime[runner] >= limit) begin
                            st[runner] = ST_READY;
                            push_ready(runner[3:0]);
                            runner = 5'h1f;
                            r.preempted = 1'b1;
                        end
                    end
                end
                KIND_SLEEP: begin
                    if (runner[4]) begin
                        r.status = STAT_IGNORED;
                    end else begin
                        wake[runner] = now + {16'd0, nap};
                        st[runner] = ST_SLEEP;
                        runner = 5'h1f;
                    end
                end
                KIND_DISPATCH: begin
                    if (!runner[4]) begin
                        id = runner[3:0];
                    end else begin
                        id = (ready_ids.size() != 0) ? ready_ids.pop_front() : 4'd0;
                        st[id] = ST_RUN;
                        runtime[id] = 0;
                        runner = {1'b0, id};
                    end
                    r.pid = id;
                    r.start = entry[id];
                end
                default: ;
            endcase
            r.running = runner;
            due.push_back(r);
        endfunction

        function void check_result(logic [55:0] data);
            sched_result_t got, exp;
            got.status = data[1:0];
            got.pid = data[5:2];
            got.running = data[10:6];
            got.preempted = data[11];
            got.woken = data[16:12];
            got.start = data[48:17];
            if (due.size() == 0) begin
                $error("result with none expected: %h", data);
                errors++;
                return;
            end
            exp = due.pop_front();
            if (got.status !== exp.status) begin
                $error("status exp %0d got %0d", exp.status, got.status); errors++;
            end
            if (got.pid !== exp.pid) begin
                $error("process_id exp %0d got %0d", exp.pid, got.pid); errors++;
            end
            if (got.running !== exp.running) begin
                $error("running_id exp %0d got %0d", exp.running, got.running); errors++;
            end
            if (got.preempted !== exp.preempted) begin
                $error("preempted exp %0d got %0d", exp.preempted, got.preempted); errors++;
            end
            if (got.woken !== exp.woken) begin
                $error("woken_count exp %0d got %0d", exp.woken, got.woken); errors++;
            end
            if (got.start !== exp.start) begin
                $error("start_address exp %h got %h", exp.start, got.start); errors++;
            end
            if (data[55:49] !== '0) begin
                $error("padding exp 0 got %h", data[55:49]); errors++;
            end
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [7:0]  i_cfg_data = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [55:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [55:0] m_axis_tdata;

    sched_scoreboard sb = new();
    bit              hold_sink = 1'b0;
    bit              stream_done = 1'b0;

    process_slot_scheduler #(.SLOT_COUNT(SLOTS)) i_dut (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic int gap_len();
        // mostly short gaps, a few long ones
        return ($urandom_range(0, 9) < 8) ? $urandom_range(0, 2) : $urandom_range(5, 40);
    endfunction

    task automatic idle_cycles(int n);
        repeat (n) @(posedge i_clk);
    endtask

    task automatic send_request(logic [2:0] kind, logic [31:0] addr, logic [15:0] nap,
                                bit gaps);
        int n;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {5'd0, nap, addr, kind};
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_request(kind, addr, nap);
        if (gaps && $urandom_range(0, 2) == 0) begin
            n = gap_len();
            if (n != 0) begin
                s_axis_tvalid <= 1'b0;
                idle_cycles(n);
            end
        end
    endtask

    // Write the slice limit once the block has drained.
    task automatic write_limit(logic [7:0] value);
        s_axis_tvalid <= 1'b0;
        while (sb.due.size() != 0) @(posedge i_clk);
        idle_cycles(SLOTS + 10);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        sb.limit = value;
    endtask

    function automatic logic [2:0] pick_kind();
        int r;
        r = $urandom_range(0, 99);
        if (r < 15) return KIND_CREATE;
        if (r < 55) return KIND_TICK;
        if (r < 70) return KIND_SLEEP;
        if (r < 75) return KIND_QUERY;
        if (r < 97) return KIND_DISPATCH;
        return 3'($urandom_range(5, 7));
    endfunction

    task automatic random_phase(int count, logic [15:0] nap_max);
        for (int n = 0; n < count; n++) begin
            send_request(pick_kind(), $urandom(),
                         ($urandom_range(0, 19) == 0) ? 16'($urandom()) :
                         16'($urandom_range(0, nap_max)), 1'b1);
        end
    endtask

    // Result side: random stalls, with one long hold-off on request.
    always @(posedge i_clk) begin
        if (m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
    end

    initial begin
        int wait_n;
        forever begin
            @(posedge i_clk);
            if (hold_sink) begin
                m_axis_tready <= 1'b0;
                idle_cycles(400);
                hold_sink = 1'b0;
            end else if ($urandom_range(0, 3) == 0) begin
                wait_n = gap_len();
                if (wait_n != 0) begin
                    m_axis_tready <= 1'b0;
                    idle_cycles(wait_n);
                end
            end
            m_axis_tready <= 1'b1;
        end
    end

    initial begin
        int drain;
        sb.clear();
        idle_cycles(10);
        i_rst_n <= 1'b1;

        // directed: fill every slot, overflow, idle and empty-runner cases
        send_request(KIND_TICK, '0, '0, 1'b0);
        send_request(KIND_SLEEP, '0, 16'hffff, 1'b0);
        send_request(KIND_QUERY, '0, '0, 1'b0);
        for (int i = 0; i < SLOTS + 1; i++)
            send_request(KIND_CREATE, (i == 1) ? 32'hffff_ffff : $urandom(), '0, 1'b0);
        send_request(3'd7, 32'hffff_ffff, 16'hffff, 1'b0);
        send_request(KIND_DISPATCH, '0, '0, 1'b0);
        send_request(KIND_DISPATCH, '0, '0, 1'b0);
        send_request(KIND_TICK, '0, '0, 1'b0);
        send_request(KIND_SLEEP, '0, 16'd0, 1'b0);
        send_request(KIND_DISPATCH, '0, '0, 1'b0);
        send_request(KIND_SLEEP, '0, 16'd1, 1'b0);
        send_request(KIND_TICK, '0, '0, 1'b0);

        // long receiver hold-off while requests keep coming
        hold_sink = 1'b1;
        random_phase(30, 8);

        write_limit(8'd1);
        random_phase(450, 6);
        write_limit(8'd255);
        random_phase(450, 20);
        write_limit(8'd0);
        random_phase(300, 4);
        write_limit(8'($urandom_range(2, 254)));
        random_phase(450, 12);
        write_limit(LIMIT_RESET);
        random_phase(200, 10);

        s_axis_tvalid <= 1'b0;
        drain = 0;
        while (sb.due.size() != 0 && drain < 20000) begin
            @(posedge i_clk);
            drain++;
        end
        idle_cycles(SLOTS + 20);
        if (sb.due.size() != 0) begin
            $error("%0d results never arrived", sb.due.size());
            sb.errors++;
        end
        if (sb.errors == 0) $display("SUCCESS");
        else $display("FAILURE");
        $finish;
    end

    initial begin
        #20ms;
        $display("FAILURE");
        $finish;
    end
endmodule

// File: filelist.f
hdl/pss_pkg.sv
hdl/process_slot_scheduler.sv
tb/tb_process_slot_scheduler.sv
